@@ rtl/palr_pkg.sv @@
// Shared types and constants for the path arc-length resampler.
// No dependencies. Used by palr_ctrl, palr_datapath and the top level.
package palr_pkg;

    localparam int unsigned SPACING_W = 20;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 20'd6554;

    // iteration counts of the shared sequential units
    localparam int unsigned ITER_W = 6;
    localparam logic [ITER_W-1:0] SQRT_STEPS  = 6'd33;
    localparam logic [ITER_W-1:0] DIV_STEPS   = 6'd34;
    localparam logic [ITER_W-1:0] RATIO_STEPS = 6'd32;
    localparam logic [2:0] LERP_LAST = 3'd4;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_EMIT_FIRST,
        OP_SQ_X,
        OP_SQ_Y,
        OP_SQ_SUM,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_PTS_INIT,
        OP_RATIO_INIT,
        OP_RATIO_STEP,
        OP_LERP,
        OP_EMIT_PT,
        OP_EMIT_END,
        OP_COMMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [2:0] fld;
    } dp_cmd_t;

    typedef struct packed {
        logic at_start;
        logic w_end;
        logic room;
        logic pt_left;
        logic ratio_skip;
    } dp_stat_t;

endpackage

@@ rtl/palr_ctrl.sv @@
// Sequencer for the resampler: steps the datapath through square, root,
// division, per-point ratio and interpolation. Depends on palr_pkg.
module palr_ctrl
    import palr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_SQX,
        S_SQY,
        S_SQSUM,
        S_SQRT,
        S_DIVI,
        S_DIV,
        S_PTI,
        S_PCHK,
        S_RINIT,
        S_RATIO,
        S_LERP,
        S_EMIT,
        S_END,
        S_COMMIT
    } state_t;

    state_t           state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.fld    = cnt_reg[2:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = stat.at_start ? S_FIRST : S_SQX;
                end
            end
            S_FIRST:
            begin
                if (stat.room)
                begin
                    cmd.op     = OP_EMIT_FIRST;
                    state_next = stat.w_end ? S_END : S_COMMIT;
                end
            end
            S_SQX:
            begin
                cmd.op     = OP_SQ_X;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.op     = OP_SQ_Y;
                state_next = S_SQSUM;
            end
            S_SQSUM:
            begin
                cmd.op     = OP_SQ_SUM;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op   = OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_STEPS - 1'b1)
                    state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_STEPS - 1'b1)
                    state_next = S_PTI;
            end
            S_PTI:
            begin
                cmd.op     = OP_PTS_INIT;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                if (stat.pt_left)
                    state_next = S_RINIT;
                else
                    state_next = stat.w_end ? S_END : S_COMMIT;
            end
            S_RINIT:
            begin
                cmd.op     = OP_RATIO_INIT;
                cnt_next   = '0;
                state_next = stat.ratio_skip ? S_LERP : S_RATIO;
            end
            S_RATIO:
            begin
                cmd.op   = OP_RATIO_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == RATIO_STEPS - 1'b1)
                begin
                    cnt_next   = '0;
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                // multiply field n while storing field n-1
                cmd.op   = OP_LERP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[2:0] == LERP_LAST)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.room)
                begin
                    cmd.op     = OP_EMIT_PT;
                    state_next = S_PCHK;
                end
            end
            S_END:
            begin
                if (stat.room)
                begin
                    cmd.op     = OP_EMIT_END;
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.op     = OP_COMMIT;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

@@ rtl/palr_datapath.sv @@
// Datapath of the resampler: waypoint and path state, shared multiplier,
// root / divide / ratio iterations and the result register. Uses palr_pkg.
module palr_datapath
    import palr_pkg::*;
#(
    parameter int unsigned MAX_POINTS_PER_SEGMENT = 62
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    input  logic                 cfg_valid,
    input  logic [SPACING_W-1:0] spacing,
    input  logic signed [31:0]   way_x,
    input  logic signed [31:0]   way_y,
    input  logic signed [31:0]   way_speed,
    input  logic signed [31:0]   way_heading,
    input  logic                 path_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   pt_x,
    output logic signed [31:0]   pt_y,
    output logic signed [31:0]   pt_speed,
    output logic signed [31:0]   pt_heading,
    output logic                 run_last,
    output logic                 path_done,
    output logic                 clipped
);

    localparam int unsigned CW = $clog2(MAX_POINTS_PER_SEGMENT + 1);
    localparam logic [33:0] MAX_N = 34'(MAX_POINTS_PER_SEGMENT);

    logic [SPACING_W-1:0] spacing_reg;
    logic [SPACING_W-1:0] carry_reg;
    logic                 at_start_reg;
    logic [31:0] w_x_reg, w_y_reg, w_s_reg, w_h_reg;
    logic        w_end_reg;
    logic [31:0] p_x_reg, p_y_reg, p_s_reg, p_h_reg;

    logic [65:0] prod_reg;
    logic [65:0] sq_reg;
    logic [32:0] root_reg;
    logic [35:0] srem_reg;
    logic [32:0] len_reg;
    logic [33:0] dnum_reg;
    logic [33:0] dq_reg;
    logic [SPACING_W:0] drem_reg;
    logic [33:0] p_reg;
    logic [CW-1:0] k_reg, n_reg;
    logic        clip_reg;
    logic [32:0] rrem_reg;
    logic [31:0] ratio_reg;
    logic        rfull_reg;
    logic [31:0] r_x_reg, r_y_reg, r_s_reg, r_h_reg;

    logic        out_valid_reg;
    logic [31:0] o_x_reg, o_y_reg, o_s_reg, o_h_reg;
    logic        o_last_reg, o_done_reg, o_clip_reg;

    logic [SPACING_W-1:0] sp_eff, c_clamp;
    logic [32:0] dx, dy, ax, ay;
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod_next;
    logic [1:0]  fm, fs;
    logic [31:0] m_a0, m_a1, s_a0, s_a1;
    logic [32:0] m_d, m_mag, s_d;
    logic [65:0] rnd;
    logic [31:0] q, lerp_val;
    logic [35:0] sq_t, sq_trial;
    logic [SPACING_W:0] dv_t;
    logic [33:0] rt_t;
    logic        room;

    function automatic logic [31:0] pick(input logic [1:0] sel, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c,
                                         input logic [31:0] d);
        logic [31:0] v;
        unique case (sel)
            2'd0:    v = a;
            2'd1:    v = b;
            2'd2:    v = c;
            default: v = d;
        endcase
        return v;
    endfunction

    assign sp_eff  = (spacing_reg == '0) ? SPACING_W'(1) : spacing_reg;
    assign c_clamp = (carry_reg > sp_eff) ? sp_eff : carry_reg;

    assign dx = {w_x_reg[31], w_x_reg} - {p_x_reg[31], p_x_reg};
    assign dy = {w_y_reg[31], w_y_reg} - {p_y_reg[31], p_y_reg};
    assign ax = dx[32] ? (33'd0 - dx) : dx;
    assign ay = dy[32] ? (33'd0 - dy) : dy;

    // field being multiplied and field being stored during interpolation
    assign fm   = cmd.fld[1:0];
    assign fs   = 2'(cmd.fld - 3'd1);
    assign m_a0 = pick(fm, p_x_reg, p_y_reg, p_s_reg, p_h_reg);
    assign m_a1 = pick(fm, w_x_reg, w_y_reg, w_s_reg, w_h_reg);
    assign s_a0 = pick(fs, p_x_reg, p_y_reg, p_s_reg, p_h_reg);
    assign s_a1 = pick(fs, w_x_reg, w_y_reg, w_s_reg, w_h_reg);
    assign m_d   = {m_a1[31], m_a1} - {m_a0[31], m_a0};
    assign m_mag = m_d[32] ? (33'd0 - m_d) : m_d;
    assign s_d   = {s_a1[31], s_a1} - {s_a0[31], s_a0};

    always_comb
    begin
        unique case (cmd.op)
            OP_SQ_X:
            begin
                mul_a = ax;
                mul_b = ax;
            end
            OP_SQ_Y:
            begin
                mul_a = ay;
                mul_b = ay;
            end
            default:
            begin
                mul_a = m_mag;
                mul_b = {1'b0, ratio_reg};
            end
        endcase
    end
    assign prod_next = mul_a * mul_b;

    // round half away from zero on the magnitude, then apply the sign
    assign rnd      = prod_reg + 66'h0_8000_0000;
    assign q        = rnd[63:32];
    assign lerp_val = rfull_reg ? s_a1 : (s_d[32] ? (s_a0 - q) : (s_a0 + q));

    assign sq_t     = {srem_reg[33:0], sq_reg[65:64]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign dv_t     = {drem_reg[SPACING_W-1:0], dnum_reg[33]};
    assign rt_t     = {rrem_reg, 1'b0};

    assign room = !out_valid_reg || !out_stall;

    assign stat.at_start   = at_start_reg;
    assign stat.w_end      = w_end_reg;
    assign stat.room       = room;
    assign stat.pt_left    = (k_reg != n_reg);
    assign stat.ratio_skip = (len_reg == '0) || (p_reg >= {1'b0, len_reg});

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= SPACING_RESET;
            carry_reg     <= '0;
            at_start_reg  <= 1'b1;
            p_x_reg       <= '0;
            p_y_reg       <= '0;
            p_s_reg       <= '0;
            p_h_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                spacing_reg <= spacing;
            if (cmd.op == OP_COMMIT)
            begin
                p_x_reg      <= w_x_reg;
                p_y_reg      <= w_y_reg;
                p_s_reg      <= w_s_reg;
                p_h_reg      <= w_h_reg;
                at_start_reg <= w_end_reg;
                carry_reg    <= (w_end_reg || at_start_reg) ? '0 : drem_reg[SPACING_W-1:0];
            end
            if (cmd.op == OP_EMIT_FIRST || cmd.op == OP_EMIT_PT || cmd.op == OP_EMIT_END)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // arithmetic and payload registers
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                w_x_reg   <= way_x;
                w_y_reg   <= way_y;
                w_s_reg   <= way_speed;
                w_h_reg   <= way_heading;
                w_end_reg <= path_end;
                clip_reg  <= 1'b0;
            end
            OP_SQ_X:
                prod_reg <= prod_next;
            OP_SQ_Y:
            begin
                prod_reg <= prod_next;
                sq_reg   <= prod_reg;
            end
            OP_SQ_SUM:
            begin
                sq_reg   <= sq_reg + prod_reg;
                root_reg <= '0;
                srem_reg <= '0;
            end
            OP_SQRT_STEP:
            begin
                sq_reg <= {sq_reg[63:0], 2'b00};
                if (sq_t >= sq_trial)
                begin
                    srem_reg <= sq_t - sq_trial;
                    root_reg <= {root_reg[31:0], 1'b1};
                end
                else
                begin
                    srem_reg <= sq_t;
                    root_reg <= {root_reg[31:0], 1'b0};
                end
            end
            OP_DIV_INIT:
            begin
                len_reg  <= root_reg;
                dnum_reg <= 34'(c_clamp) + 34'(root_reg);
                dq_reg   <= '0;
                drem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                dnum_reg <= {dnum_reg[32:0], 1'b0};
                if (dv_t >= {1'b0, sp_eff})
                begin
                    drem_reg <= dv_t - {1'b0, sp_eff};
                    dq_reg   <= {dq_reg[32:0], 1'b1};
                end
                else
                begin
                    drem_reg <= dv_t;
                    dq_reg   <= {dq_reg[32:0], 1'b0};
                end
            end
            OP_PTS_INIT:
            begin
                clip_reg <= (dq_reg > MAX_N);
                n_reg    <= (dq_reg > MAX_N) ? CW'(MAX_POINTS_PER_SEGMENT) : dq_reg[CW-1:0];
                k_reg    <= '0;
                p_reg    <= 34'(sp_eff - c_clamp);
            end
            OP_RATIO_INIT:
            begin
                ratio_reg <= '0;
                rfull_reg <= (len_reg != '0) && (p_reg >= {1'b0, len_reg});
                rrem_reg  <= p_reg[32:0];
            end
            OP_RATIO_STEP:
            begin
                if (rt_t >= {1'b0, len_reg})
                begin
                    rrem_reg  <= 33'(rt_t - {1'b0, len_reg});
                    ratio_reg <= {ratio_reg[30:0], 1'b1};
                end
                else
                begin
                    rrem_reg  <= rt_t[32:0];
                    ratio_reg <= {ratio_reg[30:0], 1'b0};
                end
            end
            OP_LERP:
            begin
                if (cmd.fld != LERP_LAST)
                    prod_reg <= prod_next;
                if (cmd.fld != 3'd0)
                begin
                    unique case (fs)
                        2'd0:    r_x_reg <= lerp_val;
                        2'd1:    r_y_reg <= lerp_val;
                        2'd2:    r_s_reg <= lerp_val;
                        default: r_h_reg <= lerp_val;
                    endcase
                end
            end
            OP_EMIT_FIRST, OP_EMIT_END:
            begin
                o_x_reg    <= w_x_reg;
                o_y_reg    <= w_y_reg;
                o_s_reg    <= w_s_reg;
                o_h_reg    <= w_h_reg;
                o_last_reg <= (cmd.op == OP_EMIT_END) || !w_end_reg;
                o_done_reg <= (cmd.op == OP_EMIT_END);
                o_clip_reg <= (cmd.op == OP_EMIT_END) && clip_reg;
            end
            OP_EMIT_PT:
            begin
                o_x_reg    <= r_x_reg;
                o_y_reg    <= r_y_reg;
                o_s_reg    <= r_s_reg;
                o_h_reg    <= r_h_reg;
                o_last_reg <= (CW'(k_reg + 1'b1) == n_reg) && !w_end_reg;
                o_done_reg <= 1'b0;
                o_clip_reg <= clip_reg;
                k_reg      <= CW'(k_reg + 1'b1);
                p_reg      <= p_reg + 34'(sp_eff);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign pt_x       = o_x_reg;
    assign pt_y       = o_y_reg;
    assign pt_speed   = o_s_reg;
    assign pt_heading = o_h_reg;
    assign run_last   = o_last_reg;
    assign path_done  = o_done_reg;
    assign clipped    = o_clip_reg;

endmodule

@@ rtl/path_arc_length_resampler_core.sv @@
// Top level of the path arc-length resampler: sequencer plus datapath.
// Depends on palr_pkg, palr_ctrl and palr_datapath.
//
//  channel   handshake              payload
//  -------   ---------------------  ----------------------------------------------
//  input     in_valid / in_stall    way_x, way_y, way_speed, way_heading, path_end
//  output    out_valid / out_stall  pt_x, pt_y, pt_speed, pt_heading,
//                                   run_last, path_done, clipped
//  config    cfg_valid / cfg_ready  spacing (cfg_ready is always high)
//
// First waypoint of a path: load, emit and commit, plus an emit for the appended end point.
// Later waypoint: segment length by a 33-step root and a 34-step divide, then each
// emitted point through the 32-step ratio divider loop.
// Reset clears path state and restores the spacing to 0.1 m; no clearing pass.
// An output stall holds the sequencer at the next point; a new request is taken
// once the previous one has its last point in the output register.
module path_arc_length_resampler_core
    import palr_pkg::*;
#(
    parameter int unsigned MAX_POINTS_PER_SEGMENT = 62
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   way_x,
    input  logic signed [31:0]   way_y,
    input  logic signed [31:0]   way_speed,
    input  logic signed [31:0]   way_heading,
    input  logic                 path_end,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [31:0]   pt_x,
    output logic signed [31:0]   pt_y,
    output logic signed [31:0]   pt_speed,
    output logic signed [31:0]   pt_heading,
    output logic                 run_last,
    output logic                 path_done,
    output logic                 clipped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SPACING_W-1:0] spacing
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    palr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    palr_datapath #(
        .MAX_POINTS_PER_SEGMENT (MAX_POINTS_PER_SEGMENT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid && cfg_ready),
        .spacing     (spacing),
        .way_x       (way_x),
        .way_y       (way_y),
        .way_speed   (way_speed),
        .way_heading (way_heading),
        .path_end    (path_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .pt_speed    (pt_speed),
        .pt_heading  (pt_heading),
        .run_last    (run_last),
        .path_done   (path_done),
        .clipped     (clipped)
    );

endmodule

@@ dv/path_arc_length_resampler_core_chk.sv @@
// Checker for the path arc-length resampler: watches the waypoint, point and
// spacing channels, predicts every point and compares. Depends on palr_pkg.
module path_arc_length_resampler_core_chk
    import palr_pkg::*;
#(
    parameter int unsigned MAX_POINTS_PER_SEGMENT = 62
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [31:0]   way_x,
    input  logic signed [31:0]   way_y,
    input  logic signed [31:0]   way_speed,
    input  logic signed [31:0]   way_heading,
    input  logic                 path_end,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [31:0]   pt_x,
    input  logic signed [31:0]   pt_y,
    input  logic signed [31:0]   pt_speed,
    input  logic signed [31:0]   pt_heading,
    input  logic                 run_last,
    input  logic                 path_done,
    input  logic                 clipped,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [SPACING_W-1:0] spacing,
    output int                   fail_count,
    output int                   points_pending
);

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] spd;
        logic signed [31:0] hdg;
        logic               last;
        logic               done;
        logic               clip;
    } point_t;

    point_t               point_q[$];
    logic [SPACING_W-1:0] step_reg;
    logic signed [31:0]   pv_x, pv_y, pv_spd, pv_hdg;
    logic [31:0]          carry;
    logic                 fresh;

    function automatic logic [32:0] seg_len(logic [65:0] v);
        logic [32:0] root;
        logic [65:0] cand;
        root = '0;
        for (int b = 32; b >= 0; b--) begin
            cand = {33'b0, root | (33'b1 << b)};
            if (cand * cand <= v)
                root = cand[32:0];
        end
        return root;
    endfunction

    // Q1.32 position along the segment, saturating at 1.0
    function automatic logic [32:0] frac_at(logic [33:0] p, logic [32:0] len);
        logic [65:0] num;
        logic [65:0] q;
        if (len == 0)
            return '0;
        if (p >= {1'b0, len})
            return 33'h1_0000_0000;
        num = {p[32:0], 32'b0};
        q = num / {33'b0, len};
        return q[32:0];
    endfunction

    function automatic logic signed [31:0] blend(logic signed [31:0] a0,
                                                 logic signed [31:0] a1,
                                                 logic [32:0] r);
        logic signed [33:0] d;
        logic [67:0]        mag;
        logic [67:0]        q;
        d   = 34'(a1) - 34'(a0);
        mag = d < 0 ? 68'(-d) : 68'(d);
        q   = (mag * {35'b0, r} + (68'd1 << 31)) >> 32;
        return d < 0 ? a0 - q[31:0] : a0 + q[31:0];
    endfunction

    task automatic queue_point(point_t pt);
        point_q.insert(point_q.size(), pt);
    endtask

    task automatic predict_points(logic signed [31:0] wx, logic signed [31:0] wy,
                                  logic signed [31:0] ws, logic signed [31:0] wh,
                                  logic w_end);
        logic [33:0] sp, c, total, n, p;
        logic [32:0] ax, ay, len, r;
        logic signed [32:0] dx, dy;
        logic [65:0] sq;
        logic        clip;
        int          first;
        point_t      pt;
        sp    = (step_reg == 0) ? 34'd1 : 34'(step_reg);
        clip  = 1'b0;
        first = point_q.size();
        if (fresh) begin
            pt = '{wx, wy, ws, wh, 1'b0, 1'b0, 1'b0};
            queue_point(pt);
            fresh = 1'b0;
            carry = '0;
        end else begin
            dx = 33'(wx) - 33'(pv_x);
            dy = 33'(wy) - 33'(pv_y);
            ax = dx < 0 ? 33'(-dx) : 33'(dx);
            ay = dy < 0 ? 33'(-dy) : 33'(dy);
            sq = {33'b0, ax} * {33'b0, ax} + {33'b0, ay} * {33'b0, ay};
            len = seg_len(sq);
            c = (34'(carry) > sp) ? sp : 34'(carry);
            total = c + 34'(len);
            n = total / sp;
            carry = 32'(total % sp);
            if (n > MAX_POINTS_PER_SEGMENT) begin
                clip = 1'b1;
                n = 34'(MAX_POINTS_PER_SEGMENT);
            end
            for (int k = 1; k <= int'(n); k++) begin
                p = 34'(k) * sp - c;
                r = frac_at(p, len);
                pt = '{blend(pv_x, wx, r), blend(pv_y, wy, r), blend(pv_spd, ws, r),
                       blend(pv_hdg, wh, r), 1'b0, 1'b0, clip};
                queue_point(pt);
            end
        end
        pv_x = wx;
        pv_y = wy;
        pv_spd = ws;
        pv_hdg = wh;
        if (w_end) begin
            pt = '{wx, wy, ws, wh, 1'b0, 1'b1, clip};
            queue_point(pt);
            fresh = 1'b1;
            carry = '0;
        end
        if (point_q.size() > first)
            point_q[point_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        point_t want;
        if (!rst_n) begin
            point_q.delete();
            step_reg   = SPACING_RESET;
            pv_x       = '0;
            pv_y       = '0;
            pv_spd     = '0;
            pv_hdg     = '0;
            carry      = '0;
            fresh      = 1'b1;
            fail_count = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (point_q.size() == 0) begin
                    $display("%0t: point with nothing expected, got x %h y %h",
                             $time, pt_x, pt_y);
                    fail_count++;
                end else begin
                    want = point_q.pop_front();
                    if ({pt_x, pt_y, pt_speed, pt_heading, run_last, path_done, clipped}
                        !== want) begin
                        $display("%0t: point mismatch exp x %h y %h spd %h hdg %h l%b d%b c%b",
                                 $time, want.x, want.y, want.spd, want.hdg,
                                 want.last, want.done, want.clip);
                        $display("%0t:                got x %h y %h spd %h hdg %h l%b d%b c%b",
                                 $time, pt_x, pt_y, pt_speed, pt_heading,
                                 run_last, path_done, clipped);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_points(way_x, way_y, way_speed, way_heading, path_end);
            if (cfg_valid && cfg_ready)
                step_reg = spacing;
        end
        points_pending = point_q.size();
    end

endmodule

@@ dv/path_arc_length_resampler_core_tb.sv @@
// Testbench top for the path arc-length resampler: clock, reset, waypoint and
// spacing stimulus, receiver stalls, verdict. Depends on palr_pkg and the checker.
module path_arc_length_resampler_core_tb;
    import palr_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_WAIT   = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [31:0]   way_x, way_y, way_speed, way_heading;
    logic                 path_end;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [31:0]   pt_x, pt_y, pt_speed, pt_heading;
    logic                 run_last, path_done, clipped;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [SPACING_W-1:0] spacing;
    int                   fail_count;
    int                   points_pending;

    int        send_idle;
    int        recv_idle;
    bit        hold_go;
    int        cycles;
    logic [19:0] cur_step;
    logic signed [31:0] walk_x, walk_y;

    path_arc_length_resampler_core dut (.*);
    path_arc_length_resampler_core_chk chk (.*);

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES) begin
                $display("path_arc_length_resampler_core_tb: errors");
                $finish;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !held) begin
                held = 1'b1;
                repeat (3000) begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle);
        end
    end

    // called at a rising edge, returns at the edge where the request is taken
    task automatic send_waypoint(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] s, logic signed [31:0] h,
                                 logic e);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        way_x       <= x;
        way_y       <= y;
        way_speed   <= s;
        way_heading <= h;
        path_end    <= e;
        forever begin
            @(negedge clk);
            if (!in_stall)
                break;
        end
        @(posedge clk);
        walk_x = x;
        walk_y = y;
    endtask

    // wait until the block is idle and every expected point has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0 || in_stall)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_spacing(logic [19:0] v);
        drain();
        cfg_valid <= 1'b1;
        spacing   <= v;
        forever begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
        cur_step = v;
    endtask

    task automatic random_waypoint();
        int eff, reach;
        logic signed [31:0] x, y;
        eff   = (cur_step == 0) ? 1 : int'(cur_step);
        reach = 8 * eff;
        if ($urandom_range(9) == 0) begin
            x = $urandom;
            y = $urandom;
        end else begin
            x = walk_x + ($urandom_range(0, 2 * reach) - reach);
            y = walk_y + ($urandom_range(0, 2 * reach) - reach);
        end
        send_waypoint(x, y, $urandom, $urandom, $urandom_range(7) == 0);
    endtask

    initial begin
        logic [19:0] plan[7];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        way_x       = '0;
        way_y       = '0;
        way_speed   = '0;
        way_heading = '0;
        path_end    = 1'b0;
        cfg_valid   = 1'b0;
        spacing     = '0;
        send_idle   = 16;
        recv_idle   = 49;
        hold_go     = 1'b0;
        cur_step    = SPACING_RESET;
        walk_x      = '0;
        walk_y      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone waypoint path, then full-range swings that clip, a zero-length hop
        send_waypoint(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b1);
        send_waypoint('0, '0, '0, '0, 1'b0);
        send_waypoint(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0);
        send_waypoint(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
        send_waypoint(32'h80000000, 32'h80000000, 32'h12345678, -32'sd5, 1'b0);
        send_waypoint(32'h80000000 + 32'sd40000, 32'h80000000 - 32'sd1, 32'h0,
                      32'hffffffff, 1'b1);
        // short path, spacing lowered in the middle
        send_waypoint(32'sd1000, -32'sd2000, 32'sd65536, 32'sd0, 1'b0);
        send_waypoint(32'sd9000, -32'sd2000, 32'sd131072, 32'sd205887, 1'b0);
        send_waypoint(32'sd13000, 32'sd1000, -32'sd65536, -32'sd205887, 1'b0);
        write_spacing(20'd700);
        send_waypoint(32'sd14000, 32'sd1500, 32'sd0, 32'sd1, 1'b0);
        send_waypoint(32'sd14000, 32'sd1500, 32'sd7, 32'sd9, 1'b0);
        send_waypoint(32'sd10000, -32'sd500, 32'sd3, -32'sd9, 1'b1);

        plan = '{20'd1, 20'd655360, 20'($urandom_range(1, 655360)), 20'd0,
                 20'hfffff, 20'($urandom_range(1, 4096)), SPACING_RESET};
        for (int ch = 0; ch < 7; ch++) begin
            write_spacing(plan[ch]);
            if (ch < 2) begin
                send_idle = 16;
                recv_idle = 49;
            end else if (ch < 4) begin
                send_idle = 49;
                recv_idle = 16;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (ch == 4)
                hold_go = 1'b1;
            repeat (30) random_waypoint();
        end

        drain();
        if (fail_count == 0)
            $display("path_arc_length_resampler_core_tb: clean");
        else
            $display("path_arc_length_resampler_core_tb: errors");
        $finish;
    end

endmodule
